// File: hw/rtl/huffman_code_bit_packer_top_assert.svh
// assertion macros for the bit packer
`ifndef HUFFMAN_CODE_BIT_PACKER_TOP_ASSERT_SVH
`define HUFFMAN_CODE_BIT_PACKER_TOP_ASSERT_SVH

// same-cycle implication
`define HCBP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HCBP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/hcbp_pkg.sv
package hcbp_pkg;

	localparam int CODE_W           = 32;
	localparam int LEN_W            = 6;
	localparam int SYM_W            = 9;
	localparam int BYTE_W           = 8;
	localparam int TABLE_DEPTH      = 257;
	localparam int MAX_CODE_LEN_DEF = 32;

	localparam logic [SYM_W-1:0] END_SYMBOL = 9'd256;

	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_ENCODE = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [SYM_W-1:0]  entry_symbol;
		logic [CODE_W-1:0] entry_code;
		logic [LEN_W-1:0]  entry_length;
		logic [BYTE_W-1:0] data_byte;
		logic              final_byte;
	} req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] packed_byte;
		logic              run_end;
		logic              stream_end;
	} rsp_t;

endpackage

// File: hw/rtl/huffman_code_bit_packer_top.sv
// channel | signals                      | beat
// --------+------------------------------+---------------------------------------
// req     | req_valid, req_ready, req    | load one code entry or encode one byte
// rsp     | rsp_valid, rsp_ready, rsp    | one packed output byte
//
// a load beat writes one table entry; an encode beat steps through read, latch, shift
// and finish, and a final byte also reads and shifts the end symbol, then flushes
// the code bits move one per cycle through the packing shift register unless it stalls
// reset clears the bit buffer and control; code table entries hold nothing until loaded
// rsp backpressure stalls the shifter only when a completed byte finds both
// the holding byte and the output register full
module huffman_code_bit_packer_top
	import hcbp_pkg::*;
#(
	parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int CW = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
	localparam int LW = $clog2(CW + 1);
	localparam int IW = (CW > 1) ? $clog2(CW) : 1;
	localparam int EW = CW + LW;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_LAT,
		S_SHIFT,
		S_FLUSH,
		S_FIN
	} st_t;

	st_t               st_q;
	logic [SYM_W-1:0]  addr_q;
	logic              fin_q;
	logic              end_done_q;
	logic [CW-1:0]     code_q;
	logic [LW-1:0]     bits_left_q;
	logic [6:0]        acc_q;
	logic [2:0]        cnt_q;
	logic [BYTE_W-1:0] hb_q;
	logic              hb_vld_q;
	rsp_t              out_q;
	logic              out_vld_q;
	logic [EW-1:0]     rd_q;

	logic [EW-1:0]     table_mem [TABLE_DEPTH];

	logic              mem_we;
	logic [LW-1:0]     wr_len;
	logic [IW-1:0]     bit_idx;
	logic              cur_bit;
	logic              out_free;
	logic              shift_ok;
	logic              out_set;
	logic [BYTE_W-1:0] pad_byte;

	assign req_ready = (st_q == S_IDLE);
	assign rsp_valid = out_vld_q;
	assign rsp       = out_q;

	assign mem_we = req_valid && req_ready && (req.req_type == REQ_LOAD)
		&& (req.entry_symbol <= END_SYMBOL);
	assign wr_len = (req.entry_length > LEN_W'(CW)) ? LW'(CW) : LW'(req.entry_length);

	assign bit_idx  = IW'(bits_left_q - 1'b1);
	assign cur_bit  = code_q[bit_idx];
	assign out_free = !out_vld_q || rsp_ready;
	assign shift_ok = !((cnt_q == 3'd7) && hb_vld_q && !out_free);
	assign pad_byte = {acc_q, 1'b0} << (3'd7 - cnt_q);

	// a beat enters the output register
	assign out_set = ((st_q == S_SHIFT) && (bits_left_q != '0) && shift_ok
			&& (cnt_q == 3'd7) && hb_vld_q)
		|| ((st_q == S_FLUSH) && (cnt_q != 3'd0) && hb_vld_q && out_free)
		|| ((st_q == S_FIN) && hb_vld_q && out_free);

	// code table, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[req.entry_symbol] <= {req.entry_code[CW-1:0], wr_len};
		end
		rd_q <= table_mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			addr_q      <= '0;
			fin_q       <= 1'b0;
			end_done_q  <= 1'b0;
			code_q      <= '0;
			bits_left_q <= '0;
			acc_q       <= '0;
			cnt_q       <= '0;
			hb_q        <= '0;
			hb_vld_q    <= 1'b0;
			out_q       <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			out_vld_q <= out_set || (out_vld_q && !rsp_ready);
			case (st_q)
				S_IDLE: begin
					if (req_valid && (req.req_type == REQ_ENCODE)) begin
						addr_q     <= {1'b0, req.data_byte};
						fin_q      <= req.final_byte;
						end_done_q <= 1'b0;
						st_q       <= S_READ;
					end
				end
				S_READ: begin
					st_q <= S_LAT;
				end
				S_LAT: begin
					code_q      <= rd_q[EW-1:LW];
					bits_left_q <= rd_q[LW-1:0];
					st_q        <= S_SHIFT;
				end
				S_SHIFT: begin
					if (bits_left_q == '0) begin
						if (fin_q && !end_done_q) begin
							addr_q     <= END_SYMBOL;
							end_done_q <= 1'b1;
							st_q       <= S_READ;
						end else if (fin_q) begin
							st_q <= S_FLUSH;
						end else begin
							st_q <= S_FIN;
						end
					end else if (shift_ok) begin
						bits_left_q <= bits_left_q - 1'b1;
						acc_q       <= {acc_q[5:0], cur_bit};
						cnt_q       <= cnt_q + 3'd1;
						if (cnt_q == 3'd7) begin
							hb_q     <= {acc_q, cur_bit};
							hb_vld_q <= 1'b1;
							if (hb_vld_q) begin
								out_q <= '{packed_byte: hb_q, run_end: 1'b0,
									stream_end: 1'b0};
							end
						end
					end
				end
				S_FLUSH: begin
					if (cnt_q == 3'd0) begin
						st_q <= S_FIN;
					end else if (!hb_vld_q || out_free) begin
						// zero-padded tail byte
						if (hb_vld_q) begin
							out_q <= '{packed_byte: hb_q, run_end: 1'b0,
								stream_end: 1'b0};
						end
						hb_q     <= pad_byte;
						hb_vld_q <= 1'b1;
						cnt_q    <= '0;
						acc_q    <= '0;
						st_q     <= S_FIN;
					end
				end
				S_FIN: begin
					if (!hb_vld_q) begin
						st_q <= S_IDLE;
					end else if (out_free) begin
						out_q    <= '{packed_byte: hb_q, run_end: 1'b1, stream_end: fin_q};
						hb_vld_q <= 1'b0;
						st_q     <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	`include "huffman_code_bit_packer_top_assert.svh"

	`HCBP_ASSERT_NOW(a_idle_no_held, req_ready, !hb_vld_q, "held byte left behind at idle")
	`HCBP_ASSERT_NOW(a_end_has_run_end, rsp_valid && rsp.stream_end, rsp.run_end,
		"stream end beat without run end")
	`HCBP_ASSERT_NOW(a_end_read_final, (st_q == S_READ) && (addr_q == END_SYMBOL) && end_done_q,
		fin_q, "end symbol read for a non-final byte")
	`HCBP_ASSERT_NOW(a_final_empty, (st_q == S_FIN) && fin_q, cnt_q == 3'd0,
		"bits left over after stream end")
	`HCBP_ASSERT_NEXT(a_fin_empty_idle, (st_q == S_FIN) && !hb_vld_q, st_q == S_IDLE,
		"finish state did not return to idle")

endmodule
